>>> hdl/running_median_two_heaps_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the running median block
// Each macro is a labeled concurrent assertion, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`ifndef SYNTHESIS
`define RMH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define RMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RMH_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define RMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/rmh_pkg.sv
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared constants and types of the running median block.
// ----------------------------------------------------------------------------
package rmh_pkg;
   localparam int unsigned CAPACITY_DEF     = 1024;
   localparam int unsigned SAMPLE_WIDTH_DEF = 16;
   localparam int unsigned COUNT_W          = 11;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;
endpackage

>>> hdl/rmh_heap_engine.sv
// ----------------------------------------------------------------------------
// rmh_heap_engine
// Dual heap store in one synchronous memory, with a sequencer that runs
// pushes and pops one level per read/compare/write round.
// ----------------------------------------------------------------------------
module rmh_heap_engine #(
   parameter int unsigned CAPACITY     = rmh_pkg::CAPACITY_DEF,
   parameter int unsigned SAMPLE_WIDTH = rmh_pkg::SAMPLE_WIDTH_DEF,
   parameter int unsigned CW           = $clog2(CAPACITY + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           start_clear,
   input  logic signed [SAMPLE_WIDTH-1:0] start_sample,
   input  logic                           hold,
   output logic                           busy,
   output logic                           done,
   output logic                           done_rejected,
   output logic signed [SAMPLE_WIDTH-1:0] done_median,
   output logic [CW-1:0]                  done_count
);
   import rmh_pkg::*;

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [AW-1:0] TOP_UP = AW'(CAPACITY - 1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DECID = 10'b0000000010,
      S_NEXT  = 10'b0000000100,
      S_PUSHR = 10'b0000001000,
      S_PUSHC = 10'b0000010000,
      S_POPL  = 10'b0000100000,
      S_POPD  = 10'b0001000000,
      S_POPR  = 10'b0010000000,
      S_POPC  = 10'b0100000000,
      S_FIN   = 10'b1000000000
   } state_type;

   // job codes for the queued heap operations
   typedef enum logic [2:0] {
      J_NONE  = 3'd0,
      J_PUSHL = 3'd1,
      J_PUSHU = 3'd2,
      J_POPL  = 3'd3,
      J_POPU  = 3'd4
   } job_type;

   logic signed [SAMPLE_WIDTH-1:0] mem [CAPACITY];
   logic                           we;
   logic [AW-1:0]                  waddr, raddr;
   logic signed [SAMPLE_WIDTH-1:0] wdata, rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   state_type state_ff, state_in;
   logic [CW-1:0] lcnt_ff, lcnt_in, ucnt_ff, ucnt_in;
   logic [CW-1:0] idx_ff, idx_in, nsz_ff, nsz_in;
   logic          up_ff, up_in;
   logic signed [SAMPLE_WIDTH-1:0] cur_ff, cur_in, smp_ff, smp_in;
   logic signed [SAMPLE_WIDTH-1:0] lval_ff, lval_in, med_ff, med_in;
   job_type       j1_ff, j1_in, j2_ff, j2_in, j3_ff, j3_in;
   logic signed [SAMPLE_WIDTH-1:0] v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic          rej_ff, rej_in;
   logic          done_ff, done_in;

   logic [CW-1:0] par, sel_cnt, sel_last;
   logic [CW:0]   lch_idx, rch_idx;
   logic          job_up, pick_r, keep_cur, par_wins;
   logic signed [SAMPLE_WIDTH-1:0] child_val;

   function automatic logic [AW-1:0] slot(input logic u, input logic [CW-1:0] k);
      slot = u ? (TOP_UP - AW'(k)) : AW'(k);
   endfunction

   assign par       = (idx_ff - CW'(1)) >> 1;
   assign lch_idx   = {idx_ff, 1'b1};
   assign rch_idx   = {idx_ff, 1'b0} + (CW+1)'(2);
   assign job_up    = (j1_ff == J_PUSHU) || (j1_ff == J_POPU);
   assign sel_cnt   = job_up ? ucnt_ff : lcnt_ff;
   assign sel_last  = sel_cnt - CW'(1);
   assign pick_r    = (rch_idx < {1'b0, nsz_ff}) &&
                      (up_ff ? (rdata_ff < lval_ff) : (rdata_ff > lval_ff));
   assign child_val = pick_r ? rdata_ff : lval_ff;
   assign keep_cur  = up_ff ? (cur_ff <= child_val) : (cur_ff >= child_val);
   assign par_wins  = up_ff ? (rdata_ff <= cur_ff) : (rdata_ff >= cur_ff);

   always_comb begin
      state_in = state_ff;
      lcnt_in = lcnt_ff; ucnt_in = ucnt_ff;
      idx_in = idx_ff; nsz_in = nsz_ff; up_in = up_ff;
      cur_in = cur_ff; smp_in = smp_ff; lval_in = lval_ff; med_in = med_ff;
      j1_in = j1_ff; j2_in = j2_ff; j3_in = j3_ff;
      v1_in = v1_ff; v2_in = v2_ff; v3_in = v3_ff;
      rej_in = rej_ff; done_in = 1'b0;
      we = 1'b0; waddr = '0; wdata = cur_ff; raddr = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               smp_in = start_sample;
               rej_in = 1'b0;
               if (start_clear) begin
                  lcnt_in = '0; ucnt_in = '0; state_in = S_FIN;
               end else if ({1'b0, lcnt_ff} + {1'b0, ucnt_ff} >= (CW+1)'(CAPACITY)) begin
                  rej_in = 1'b1; state_in = S_FIN;
               end else if (lcnt_ff == '0 && ucnt_ff == '0) begin
                  j1_in = J_PUSHL; v1_in = start_sample; j2_in = J_NONE; j3_in = J_NONE;
                  state_in = S_NEXT;
               end else begin
                  raddr = (lcnt_ff == ucnt_ff) ? TOP_UP : '0;
                  state_in = S_DECID;
               end
            end
         end
         S_DECID: begin
            if (lcnt_ff == ucnt_ff) begin
               if (smp_ff <= rdata_ff) begin
                  j1_in = J_PUSHL; v1_in = smp_ff; j2_in = J_NONE; j3_in = J_NONE;
               end else begin
                  j1_in = J_POPU; j2_in = J_PUSHL; v2_in = rdata_ff;
                  j3_in = J_PUSHU; v3_in = smp_ff;
               end
            end else begin
               if (smp_ff <= rdata_ff) begin
                  j1_in = J_POPL; j2_in = J_PUSHU; v2_in = rdata_ff;
                  j3_in = J_PUSHL; v3_in = smp_ff;
               end else begin
                  j1_in = J_PUSHU; v1_in = smp_ff; j2_in = J_NONE; j3_in = J_NONE;
               end
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            j1_in = j2_ff; v1_in = v2_ff; j2_in = j3_ff; v2_in = v3_ff; j3_in = J_NONE;
            case (j1_ff) inside
               J_PUSHL, J_PUSHU: begin
                  up_in  = job_up;
                  idx_in = sel_cnt;
                  cur_in = v1_ff;
                  if (job_up) ucnt_in = ucnt_ff + CW'(1);
                  else lcnt_in = lcnt_ff + CW'(1);
                  state_in = S_PUSHR;
               end
               J_POPL, J_POPU: begin
                  up_in  = job_up;
                  nsz_in = sel_last;
                  if (job_up) ucnt_in = sel_last;
                  else lcnt_in = sel_last;
                  raddr  = slot(job_up, sel_last);
                  idx_in = '0;
                  state_in = S_POPL;
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_PUSHR: begin
            if (idx_ff == '0) begin
               we = 1'b1; waddr = slot(up_ff, idx_ff); wdata = cur_ff;
               state_in = S_NEXT;
            end else begin
               raddr = slot(up_ff, par);
               state_in = S_PUSHC;
            end
         end
         S_PUSHC: begin
            we = 1'b1; waddr = slot(up_ff, idx_ff);
            if (par_wins) begin
               wdata = cur_ff;
               state_in = S_NEXT;
            end else begin
               wdata = rdata_ff;
               idx_in = par;
               state_in = S_PUSHR;
            end
         end
         S_POPL: begin
            cur_in = rdata_ff;
            state_in = S_POPD;
         end
         S_POPD: begin
            if (lch_idx >= {1'b0, nsz_ff}) begin
               we = 1'b1; waddr = slot(up_ff, idx_ff); wdata = cur_ff;
               state_in = S_NEXT;
            end else begin
               raddr = slot(up_ff, CW'(lch_idx));
               state_in = S_POPR;
            end
         end
         S_POPR: begin
            lval_in = rdata_ff;
            raddr = slot(up_ff, CW'(rch_idx));
            state_in = S_POPC;
         end
         S_POPC: begin
            we = 1'b1; waddr = slot(up_ff, idx_ff);
            if (keep_cur) begin
               wdata = cur_ff;
               state_in = S_NEXT;
            end else begin
               wdata = child_val;
               idx_in = pick_r ? CW'(rch_idx) : CW'(lch_idx);
               state_in = S_POPD;
            end
         end
         S_FIN: begin
            // root read stays on address zero while the result is held back
            if (!hold) begin
               done_in = 1'b1;
               med_in = (lcnt_ff != '0) ? rdata_ff : '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lcnt_ff  <= '0;
         ucnt_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         lcnt_ff  <= lcnt_in;
         ucnt_ff  <= ucnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; nsz_ff <= nsz_in; up_ff <= up_in;
      cur_ff <= cur_in; smp_ff <= smp_in; lval_ff <= lval_in;
      med_ff <= med_in;
      j1_ff <= j1_in; j2_ff <= j2_in; j3_ff <= j3_in;
      v1_ff <= v1_in; v2_ff <= v2_in; v3_ff <= v3_in;
      rej_ff <= rej_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign done          = done_ff;
   assign done_rejected = rej_ff;
   assign done_median   = med_ff;
   assign done_count    = lcnt_ff + ucnt_ff;
endmodule

>>> hdl/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Streaming lower median over signed samples, dual heap in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one transaction: req_op (insert or clear) and
//   req_sample. rsp_ channel returns one transaction per request: median,
//   count, rejected and empty_res.
//   Sequencing: a clear or a rejected insert goes straight to the result;
//   an insert runs up to three heap operations; a push level reads, then
//   writes; a pop level reads both children, then compares and writes.
//   Throughput: one transaction at a time; the next request is taken once
//   the result sits in the output register, while it waits for rsp_ready.
//   Reset: both heaps are emptied; memory contents are not cleared.
//   A stalled receiver holds the output register; the engine finishes the
//   next transaction and waits to hand its result over, and no further
//   request is taken until the register drains.
// ----------------------------------------------------------------------------
`include "running_median_two_heaps_macros.svh"
module running_median_two_heaps #(
   parameter int unsigned CAPACITY     = rmh_pkg::CAPACITY_DEF,
   parameter int unsigned SAMPLE_WIDTH = rmh_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [0:0]                       req_op,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_median,
   output logic [rmh_pkg::COUNT_W-1:0]      rsp_count,
   output logic                             rsp_rejected,
   output logic                             rsp_empty_res
);
   import rmh_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic busy, done, d_rej;
   logic signed [SAMPLE_WIDTH-1:0] d_med;
   logic [CW-1:0] d_cnt;
   logic valid_ff, valid_in, pend_ff, pend_in;
   logic signed [SAMPLE_WIDTH-1:0] med_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic rej_ff, emp_ff;
   logic start, out_hold;

   assign req_ready = !busy && !pend_ff;
   assign start     = req_valid && req_ready;
   assign out_hold  = valid_ff && !rsp_ready;

   rmh_heap_engine #(.CAPACITY(CAPACITY), .SAMPLE_WIDTH(SAMPLE_WIDTH), .CW(CW)) u_eng (
      .clock, .reset, .start,
      .start_clear(req_op == OP_CLEAR),
      .start_sample(req_sample),
      .hold(out_hold),
      .busy, .done, .done_rejected(d_rej), .done_median(d_med), .done_count(d_cnt)
   );

   always_comb begin
      pend_in  = pend_ff;
      valid_in = valid_ff;
      if (start) pend_in = 1'b1;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      if (done) begin pend_in = 1'b0; valid_in = 1'b1; end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         med_ff <= d_med;
         cnt_ff <= COUNT_W'(d_cnt);
         rej_ff <= d_rej;
         emp_ff <= (d_cnt == '0);
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_median    = med_ff;
   assign rsp_count     = cnt_ff;
   assign rsp_rejected  = rej_ff;
   assign rsp_empty_res = emp_ff;

   `RMH_ASSERT_IMPL(a_no_overlap, clock, reset, start, !pend_ff, "start while busy")
   `RMH_ASSERT_IMPL(a_done_pend, clock, reset, done, pend_ff, "done without request")
   `RMH_ASSERT_IMPL(a_done_free, clock, reset, done, !valid_ff, "result overwritten")
   `RMH_ASSERT_NEXT(a_empty_med, clock, reset, done && d_cnt == '0, rsp_median == '0, "empty median")
endmodule
